@@ sv/cht_pkg.sv @@
// Shared types and constants for the coalesced hash table.
`timescale 1ns / 1ps

package cht_pkg;

    localparam logic [31:0] GOLDEN_Q32 = 32'h9E37_79B9;
    localparam logic [10:0] HIT_MAX    = 11'd2047;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture item, start hash multiply
        logic calc_home;   // latch hash fraction for scaling to home slot
        logic rd_home;     // read home slot
        logic rd_cur;      // read chain slot
        logic rd_fp;       // read free pointer slot
        logic step_link;   // follow link to next slot
        logic dec_fp;      // move free pointer down
        logic wr_home_new; // write home slot as fresh entry
        logic wr_link;     // write scanned slot with the home slot's old link
        logic res_insert;  // latch insert result
        logic res_found;
        logic res_miss;
        logic res_full;
        logic clear_step;  // clearing pass: clear one entry
    } cht_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic home_used;
        logic cur_match;
        logic cur_end;
        logic fp_used;
        logic fp_neg;
        logic steps_done;
        logic clear_last;
    } cht_sts_t;

endpackage

@@ sv/cht_datapath.sv @@
// Datapath for the coalesced hash table: memories, hash, pointers, result.
`timescale 1ns / 1ps

module cht_datapath #(
    parameter int CAPACITY = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cht_pkg::cht_cmd_t       cmd,
    output cht_pkg::cht_sts_t       sts,
    input  logic                    cfg_write,
    input  logic [10:0]             cfg_data,
    input  logic [31:0]             key_hash,
    input  logic [7:0]              left_code,
    input  logic [7:0]              right_code,
    input  logic [30:0]             wave_offset,
    input  logic [15:0]             half_segment,
    input  logic [30:0]             mark_offset,
    input  logic [7:0]              frame_count,
    output logic [1:0]              status,
    output logic [9:0]              slot,
    output logic [30:0]             found_wave_offset,
    output logic [15:0]             found_half_segment,
    output logic [30:0]             found_mark_offset,
    output logic [7:0]              found_frame_count
);
    localparam int AW = $clog2(CAPACITY);
    localparam int SW = $clog2(CAPACITY + 1);
    localparam int PW = 31 + 16 + 31 + 8;

    // memories
    logic [10:0]     hit_mem  [CAPACITY];
    logic [AW:0]     link_mem [CAPACITY];   // MSB set = end of chain
    logic [15:0]     key_mem  [CAPACITY];
    logic [PW-1:0]   pay_mem  [CAPACITY];

    logic [SW-1:0]   size_reg, size_next;
    logic [AW:0]     fp_reg;                // MSB set = exhausted
    logic [AW-1:0]   clr_reg;
    logic [31:0]     hash_reg;
    logic [15:0]     key_reg;
    logic [PW-1:0]   pay_reg;
    logic [31:0]     frac_reg;
    logic [AW-1:0]   home_reg, cur_reg;
    logic [SW-1:0]   steps_reg;
    logic [10:0]     rd_hit;
    logic [AW:0]     rd_link;
    logic [15:0]     rd_key;
    logic [PW-1:0]   rd_pay;
    logic [AW:0]     home_link_reg;
    logic [10:0]     home_hit_reg;
    logic [1:0]      status_reg;
    logic [9:0]      slot_reg;
    logic [PW-1:0]   fpay_reg;

    logic [31:0]     scale_prod_hi;
    logic [63:0]     prod;
    logic [AW:0]     end_mark;

    assign end_mark = {1'b1, {AW{1'b0}}};

    always_comb
    begin
        size_next = size_reg;
        if (cfg_data < 11'd2)
            size_next = SW'(2);
        else if ({21'd0, cfg_data} > 32'(CAPACITY))
            size_next = SW'(CAPACITY);
        else
            size_next = SW'(cfg_data);
    end

    assign prod          = {32'd0, frac_reg} * {{(64 - SW){1'b0}}, size_reg};
    assign scale_prod_hi = prod[63:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SW'(CAPACITY);
            fp_reg   <= (AW + 1)'(CAPACITY - 1);
            clr_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                size_reg <= size_next;
                fp_reg   <= (AW + 1)'(size_next - SW'(1));
                clr_reg  <= '0;
            end
            else
            begin
                if (cmd.clear_step)
                    clr_reg <= clr_reg + AW'(1);
                if (cmd.dec_fp)
                    fp_reg <= fp_reg - (AW + 1)'(1);
            end
        end
    end

    // hit count memory, also swept by the clearing pass
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            hit_mem[clr_reg] <= '0;
        else if (cmd.wr_home_new)
            hit_mem[home_reg] <= 11'd1;
        else if (cmd.wr_link)
            hit_mem[fp_reg[AW-1:0]] <= 11'd1;
        else if (cmd.res_insert && home_hit_reg != 11'd0)
            hit_mem[home_reg] <= (home_hit_reg == cht_pkg::HIT_MAX) ? home_hit_reg
                                                                     : home_hit_reg + 11'd1;
    end

    // free pointer already moved past the new slot when the home link is written
    always_ff @(posedge clk)
    begin
        if (cmd.wr_home_new)
            link_mem[home_reg] <= end_mark;
        else if (cmd.wr_link)
            link_mem[fp_reg[AW-1:0]] <= home_link_reg;
        else if (cmd.res_insert && home_hit_reg != 11'd0)
            link_mem[home_reg] <= {1'b0, fp_reg[AW-1:0] + AW'(1)};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_home_new)
        begin
            key_mem[home_reg] <= key_reg;
            pay_mem[home_reg] <= pay_reg;
        end
        else if (cmd.wr_link)
        begin
            key_mem[fp_reg[AW-1:0]] <= key_reg;
            pay_mem[fp_reg[AW-1:0]] <= pay_reg;
        end
    end

    // single read port, address chosen by command
    logic [AW-1:0] rd_addr;
    always_comb
    begin
        rd_addr = cur_reg;
        if (cmd.rd_home)
            rd_addr = AW'(scale_prod_hi);
        else if (cmd.rd_fp)
            rd_addr = fp_reg[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_home || cmd.rd_cur || cmd.rd_fp)
        begin
            rd_hit  <= hit_mem[rd_addr];
            rd_link <= link_mem[rd_addr];
            rd_key  <= key_mem[rd_addr];
            rd_pay  <= pay_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hash_reg <= key_hash * cht_pkg::GOLDEN_Q32;
            key_reg  <= {left_code, right_code};
            pay_reg  <= {wave_offset, half_segment, mark_offset, frame_count};
        end
        if (cmd.calc_home)
            frac_reg <= hash_reg;
        if (cmd.rd_home)
        begin
            home_reg  <= AW'(scale_prod_hi);
            cur_reg   <= AW'(scale_prod_hi);
            steps_reg <= '0;
        end
        if (cmd.step_link)
        begin
            cur_reg   <= rd_link[AW-1:0];
            steps_reg <= steps_reg + SW'(1);
        end
    end

    // remember home slot contents after its read
    logic home_seen_reg;
    always_ff @(posedge clk)
    begin
        home_seen_reg <= cmd.rd_home;
        if (home_seen_reg)
        begin
            home_hit_reg  <= rd_hit;
            home_link_reg <= rd_link;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_insert)
        begin
            status_reg <= cht_pkg::ST_INSERTED;
            fpay_reg   <= '0;
            if (cmd.wr_home_new)
                slot_reg <= 10'(home_reg);
            else
                slot_reg <= 10'(fp_reg[AW-1:0] + AW'(1));
        end
        else if (cmd.res_found)
        begin
            status_reg <= cht_pkg::ST_FOUND;
            slot_reg   <= 10'(cur_reg);
            fpay_reg   <= rd_pay;
        end
        else if (cmd.res_miss || cmd.res_full)
        begin
            status_reg <= cmd.res_full ? cht_pkg::ST_FULL : cht_pkg::ST_NOT_FOUND;
            slot_reg   <= '0;
            fpay_reg   <= '0;
        end
    end

    assign sts.home_used  = rd_hit != 11'd0;
    assign sts.cur_match  = rd_key == key_reg;
    assign sts.cur_end    = rd_link[AW];
    assign sts.fp_used    = rd_hit != 11'd0;
    assign sts.fp_neg     = fp_reg[AW];
    assign sts.steps_done = steps_reg >= SW'(CAPACITY - 1);
    assign sts.clear_last = clr_reg == AW'(CAPACITY - 1);

    assign status             = status_reg;
    assign slot               = slot_reg;
    assign found_wave_offset  = fpay_reg[PW-1 -: 31];
    assign found_half_segment = fpay_reg[54:39];
    assign found_mark_offset  = fpay_reg[38:8];
    assign found_frame_count  = fpay_reg[7:0];

endmodule

@@ sv/cht_ctrl.sv @@
// Controller state machine for the coalesced hash table.
`timescale 1ns / 1ps

module cht_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    output logic               out_valid,
    input  logic               out_ready,
    input  logic               cfg_write,
    output cht_pkg::cht_cmd_t  cmd,
    input  cht_pkg::cht_sts_t  sts
);
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HOME,
        S_HOME_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_LINK,
        S_WALK_RD,
        S_WALK_CHK,
        S_RESULT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   op_reg, op_next;
    logic   ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && (!ov_reg || out_ready))
                begin
                    cmd.load   = 1'b1;
                    op_next    = op;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.calc_home = 1'b1;
                state_next    = S_HOME;
            end
            S_HOME:
            begin
                cmd.rd_home = 1'b1;
                state_next  = S_HOME_CHK;
            end
            S_HOME_CHK:
            begin
                if (!op_reg)
                begin
                    if (!sts.home_used)
                    begin
                        cmd.wr_home_new = 1'b1;
                        cmd.res_insert  = 1'b1;
                        state_next      = S_DONE;
                    end
                    else
                        state_next = S_SCAN_RD;
                end
                else if (!sts.home_used)
                begin
                    cmd.res_miss = 1'b1;
                    state_next   = S_DONE;
                end
                else if (sts.cur_match)
                begin
                    cmd.res_found = 1'b1;
                    state_next    = S_DONE;
                end
                else if (sts.cur_end || sts.steps_done)
                begin
                    cmd.res_miss = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.step_link = 1'b1;
                    state_next    = S_WALK_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (sts.fp_neg)
                begin
                    cmd.res_full = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.rd_fp  = 1'b1;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (sts.fp_used)
                begin
                    cmd.dec_fp = 1'b1;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    cmd.wr_link = 1'b1;
                    cmd.dec_fp  = 1'b1;
                    state_next  = S_LINK;
                end
            end
            S_LINK:
            begin
                cmd.res_insert = 1'b1;
                state_next     = S_DONE;
            end
            S_WALK_RD:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                if (sts.cur_match)
                begin
                    cmd.res_found = 1'b1;
                    state_next    = S_DONE;
                end
                else if (sts.cur_end || sts.steps_done)
                begin
                    cmd.res_miss = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.step_link = 1'b1;
                    state_next    = S_WALK_RD;
                end
            end
            S_RESULT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_write)
            state_next = S_CLEAR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            op_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign out_valid = ov_reg;

endmodule

@@ sv/coalesced_hash_table_core.sv @@
// Top level of the coalesced-chaining hash table.
`timescale 1ns / 1ps

// Coalesced-chaining hash table of CAPACITY slots, one insert or search per
// transaction and one result transaction each. The home slot is
// ((hash * 0x9E3779B9 mod 2^32) * size) >> 32. An insert whose home slot is
// taken inspects slots downward from the free pointer; a search follows the
// chain links from the home slot. All table reads go through one registered
// memory read port. After reset and after every table_size write, a clearing
// pass sweeps the hit counts; no item is taken meanwhile. The result is held
// in an output register, so a new item may be accepted in the same cycle the
// previous result transaction completes.
module coalesced_hash_table_core #(
    parameter int CAPACITY = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] table_size,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [31:0] key_hash,
    input  logic [7:0]  left_code,
    input  logic [7:0]  right_code,
    input  logic [30:0] wave_offset,
    input  logic [15:0] half_segment,
    input  logic [30:0] mark_offset,
    input  logic [7:0]  frame_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [9:0]  slot,
    output logic [30:0] found_wave_offset,
    output logic [15:0] found_half_segment,
    output logic [30:0] found_mark_offset,
    output logic [7:0]  found_frame_count
);
    cht_pkg::cht_cmd_t cmd;
    cht_pkg::cht_sts_t sts;
    logic              cfg_write;

    // configuration is always taken; it restarts the clearing pass
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;

    cht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_write (cfg_write),
        .cmd       (cmd),
        .sts       (sts)
    );

    cht_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_write          (cfg_write),
        .cfg_data           (table_size),
        .key_hash           (key_hash),
        .left_code          (left_code),
        .right_code         (right_code),
        .wave_offset        (wave_offset),
        .half_segment       (half_segment),
        .mark_offset        (mark_offset),
        .frame_count        (frame_count),
        .status             (status),
        .slot               (slot),
        .found_wave_offset  (found_wave_offset),
        .found_half_segment (found_half_segment),
        .found_mark_offset  (found_mark_offset),
        .found_frame_count  (found_frame_count)
    );

endmodule

@@ verif/coalesced_hash_table_core_tb.sv @@
// Self-checking testbench for the coalesced hash table core.
`timescale 1ns / 1ps

// Scoreboard: mirrors the table state and queues the predicted result of each
// accepted transaction; results are checked in order.
class cht_scoreboard;
    int unsigned    size;
    logic [10:0]    hits [1024];
    logic [15:0]    link [1024];
    logic [7:0]     lcode [1024];
    logic [7:0]     rcode [1024];
    logic [30:0]    pwave [1024];
    logic [15:0]    phalf [1024];
    logic [30:0]    pmark [1024];
    logic [7:0]     pframe [1024];
    int             free_ptr;
    logic [97:0]    pending [$];
    int             errors;
    int             checked;
    int             n_full;
    int             n_found;
    int             n_miss;

    function void set_size(logic [10:0] value);
        size = 32'(value);
        if (size < 2) size = 2;
        if (size > 1024) size = 1024;
        for (int i = 0; i < 1024; i++) hits[i] = '0;
        free_ptr = int'(size) - 1;
    endfunction

    function int unsigned home_of(logic [31:0] key);
        logic [31:0] frac;
        logic [63:0] prod;
        frac = key * cht_pkg::GOLDEN_Q32;
        prod = {32'd0, frac} * {32'd0, size};
        return prod[63:32];
    endfunction

    // Predict one accepted input transaction.
    function void note_item(logic op_i, logic [31:0] key, logic [7:0] lc, logic [7:0] rc,
                            logic [30:0] wv, logic [15:0] hs, logic [30:0] mk,
                            logic [7:0] fc);
        int unsigned home;
        int unsigned cur;
        int unsigned chosen;
        int fp;
        cht_pkg::status_t st;
        logic [9:0] sl;
        logic [85:0] pay;
        bit live;
        home = home_of(key);
        sl = '0;
        pay = '0;
        chosen = 0;
        if (op_i == 1'b0)
        begin
            st = cht_pkg::ST_INSERTED;
            if (hits[home] == 0)
            begin
                chosen = home;
                link[chosen] = 16'hFFFF;
            end
            else
            begin
                fp = free_ptr;
                while (fp >= 0 && hits[fp] != 0) fp--;
                if (fp < 0)
                begin
                    free_ptr = -1;
                    st = cht_pkg::ST_FULL;
                    n_full++;
                end
                else
                begin
                    chosen = fp;
                    link[chosen] = link[home];
                    link[home] = 16'(chosen);
                    if (hits[home] < cht_pkg::HIT_MAX) hits[home]++;
                    free_ptr = fp - 1;
                end
            end
            if (st == cht_pkg::ST_INSERTED)
            begin
                hits[chosen] = 11'd1;
                lcode[chosen] = lc;
                rcode[chosen] = rc;
                pwave[chosen] = wv;
                phalf[chosen] = hs;
                pmark[chosen] = mk;
                pframe[chosen] = fc;
                sl = 10'(chosen);
            end
        end
        else
        begin
            st = cht_pkg::ST_NOT_FOUND;
            cur = home;
            live = hits[home] != 0;
            for (int s = 0; live && s < 1024; s++)
            begin
                if (lcode[cur] == lc && rcode[cur] == rc)
                begin
                    st = cht_pkg::ST_FOUND;
                    sl = 10'(cur);
                    pay = {pwave[cur], phalf[cur], pmark[cur], pframe[cur]};
                    live = 0;
                end
                else if (link[cur] == 16'hFFFF)
                begin
                    live = 0;
                end
                else
                begin
                    cur = 32'(link[cur] % 16'd1024);
                end
            end
            if (st == cht_pkg::ST_FOUND) n_found++;
            else n_miss++;
        end
        pending.push_back({st, sl, pay});
    endfunction

    // Compare one accepted result transaction with the oldest prediction.
    function void check_result(logic [97:0] got);
        logic [97:0] want;
        checked++;
        if (pending.size() == 0)
        begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch st %0d/%0d slot %0d/%0d pay %h/%h",
                         want[97:96], got[97:96], want[95:86], got[95:86],
                         want[85:0], got[85:0]);
        end
    endfunction
endclass

module coalesced_hash_table_core_tb;
    localparam int WATCHDOG = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] table_size = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        op = 1'b0;
    logic [31:0] key_hash = '0;
    logic [7:0]  left_code = '0;
    logic [7:0]  right_code = '0;
    logic [30:0] wave_offset = '0;
    logic [15:0] half_segment = '0;
    logic [30:0] mark_offset = '0;
    logic [7:0]  frame_count = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [9:0]  slot;
    logic [30:0] found_wave_offset;
    logic [15:0] found_half_segment;
    logic [30:0] found_mark_offset;
    logic [7:0]  found_frame_count;

    cht_scoreboard board;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  recv_hold = 0;     // cycles the receiver must stay stalled
    int  quiet = 0;
    int  n_sizes = 0;
    int  n_items = 0;
    logic [7:0] key_lc [$];  // first 64 inserted keys per table size, reused by searches
    logic [7:0] key_rc [$];
    logic [31:0] key_h [$];

    always #1 clk = ~clk;

    coalesced_hash_table_core dut (.*);

    // Receiver: random stalls plus an optional long hold-off.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result({status, slot, found_wave_offset, found_half_segment,
                                found_mark_offset, found_frame_count});
        if (recv_hold > 0)
        begin
            recv_hold <= recv_hold - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: counts cycles without any accepted transaction.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !rst_n || recv_hold > 0)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > WATCHDOG)
        begin
            $display("coalesced_hash_table_core_tb: done, errors");
            $finish;
        end
    end

    // Sender goes quiet, then waits for every outstanding result.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Write table_size while idle; the clearing pass holds off in_ready.
    task automatic write_size(logic [10:0] value);
        drain();
        cfg_valid <= 1'b1;
        table_size <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_size(value);
        n_sizes++;
        cfg_valid <= 1'b0;
        key_lc.delete();
        key_rc.delete();
        key_h.delete();
    endtask

    // Valid stays up after acceptance only when the next transaction follows at once.
    task automatic send_item(logic o, logic [31:0] kh, logic [7:0] lc, logic [7:0] rc,
                             logic [30:0] wv, logic [15:0] hs, logic [30:0] mk,
                             logic [7:0] fc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        key_hash <= kh;
        left_code <= lc;
        right_code <= rc;
        wave_offset <= wv;
        half_segment <= hs;
        mark_offset <= mk;
        frame_count <= fc;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_item(o, kh, lc, rc, wv, hs, mk, fc);
        n_items++;
        if (o == 1'b0 && key_lc.size() < 64)
        begin
            key_lc.push_back(lc);
            key_rc.push_back(rc);
            key_h.push_back(kh);
        end
    endtask

    // Searches mostly reuse inserted keys; codes kept in small ranges to force collisions.
    task automatic random_item();
        logic o;
        logic [31:0] kh;
        logic [7:0] lc;
        logic [7:0] rc;
        int pick;
        o = 1'($urandom_range(1));
        kh = $urandom;
        lc = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
        rc = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
        if ($urandom_range(3) == 0) kh = $urandom_range(7);
        if (o && key_lc.size() != 0 && $urandom_range(3) != 0)
        begin
            pick = $urandom_range(key_lc.size() - 1);
            kh = key_h[pick];
            lc = key_lc[pick];
            rc = key_rc[pick];
        end
        send_item(o, kh, lc, rc, 31'($urandom), 16'($urandom), 31'($urandom),
                  8'($urandom));
    endtask

    task automatic random_phase(int count, logic [10:0] sz);
        write_size(sz);
        for (int i = 0; i < count; i++) random_item();
    endtask

    initial
    begin
        board = new();
        board.set_size(11'd1024);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (1100) @(posedge clk);   // clearing pass after reset

        // Directed: extremes of fields, duplicates, chain walk, misses, full table.
        send_item(1'b1, 32'h0, 8'h00, 8'h00, '0, '0, '0, '0);
        send_item(1'b0, 32'h0, 8'h00, 8'h00, '0, '0, '0, '0);
        send_item(1'b0, 32'hFFFF_FFFF, 8'hFF, 8'hFF, '1, 16'h7FFF, '1, 8'hFF);
        send_item(1'b0, 32'h8000_0000, 8'h12, 8'h34, '1, 16'h8000, '0, 8'h80);
        send_item(1'b0, 32'h0, 8'h01, 8'h02, 31'h1234, 16'hFFFF, 31'h5678, 8'h01);
        send_item(1'b0, 32'h0, 8'h01, 8'h02, 31'h9999, 16'h0001, 31'h7777, 8'h02);
        send_item(1'b1, 32'h0, 8'h01, 8'h02, '0, '0, '0, '0);
        send_item(1'b1, 32'h0, 8'hAA, 8'hBB, '0, '0, '0, '0);
        send_item(1'b1, 32'hFFFF_FFFF, 8'hFF, 8'hFF, '0, '0, '0, '0);
        send_item(1'b1, 32'h7FFF_FFFF, 8'h00, 8'h00, '0, '0, '0, '0);
        write_size(11'd2);
        send_item(1'b0, 32'h5, 8'h01, 8'h01, 31'h1, 16'h1, 31'h1, 8'h1);
        send_item(1'b0, 32'h5, 8'h02, 8'h02, 31'h2, 16'h2, 31'h2, 8'h2);
        send_item(1'b0, 32'h5, 8'h03, 8'h03, 31'h3, 16'h3, 31'h3, 8'h3);
        send_item(1'b0, 32'h6, 8'h04, 8'h04, 31'h4, 16'h4, 31'h4, 8'h4);
        send_item(1'b1, 32'h5, 8'h02, 8'h02, '0, '0, '0, '0);
        write_size(11'd0);              // saturates to the smallest size
        send_item(1'b0, 32'h1, 8'h01, 8'h01, 31'h1, 16'h1, 31'h1, 8'h1);
        send_item(1'b1, 32'h1, 8'h01, 8'h01, '0, '0, '0, '0);
        write_size(11'h7FF);            // saturates to the capacity

        // Hit count growth: many inserts sharing one home slot.
        for (int i = 0; i < 120; i++)
            send_item(1'b0, 32'h0, 8'(i), 8'h5A, 31'(i), 16'(i), 31'(i), 8'(i));

        // Long receiver hold-off so the core fills and stalls its input.
        recv_hold <= 400;
        for (int i = 0; i < 20; i++) random_item();
        drain();    // sender pauses until every result is back

        send_idle_pct = 12;
        recv_idle_pct = 58;
        random_phase(150, 11'd16);
        random_phase(300, 11'd64);
        send_idle_pct = 58;
        recv_idle_pct = 12;
        random_phase(150, 11'd3);
        random_phase(300, 11'd1024);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(300, 11'd200);
        random_phase(150, 11'd8);
        drain();

        $display("covered %0d items over %0d table sizes: %0d found, %0d missed, %0d full",
                 n_items, n_sizes, board.n_found, board.n_miss, board.n_full);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("coalesced_hash_table_core_tb: done, clean");
        else
            $display("coalesced_hash_table_core_tb: done, errors");
        $finish;
    end
endmodule

@@ sim.f @@
sv/cht_pkg.sv
sv/cht_datapath.sv
sv/cht_ctrl.sv
sv/coalesced_hash_table_core.sv
verif/coalesced_hash_table_core_tb.sv
